/* hdl/i2c_slave_memory_emulation_macros.svh */
`ifndef I2C_SLAVE_MEMORY_EMULATION_MACROS_SVH
`define I2C_SLAVE_MEMORY_EMULATION_MACROS_SVH

// same-cycle implication, disabled in reset
`define I2C_SME_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c_sme: same-cycle check failed");

// next-cycle implication, disabled in reset
`define I2C_SME_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c_sme: next-cycle check failed");

`endif

/* hdl/i2c_sme_pkg.sv */
package i2c_sme_pkg;

  localparam int RECV_BYTES    = 16;
  localparam int MEM_ADDR_BITS = 15;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;
  localparam int KW            = $clog2(RECV_BYTES);

  typedef logic [MEM_ADDR_BITS-1:0] addr_t;
  typedef logic [KW-1:0]            kidx_t;
  typedef logic [7:0]               byte_t;

  // shared address adder operand select
  typedef logic [1:0] au_op_t;
  localparam au_op_t AU_CLR    = 2'd0;
  localparam au_op_t AU_PTR    = 2'd1;
  localparam au_op_t AU_COMMIT = 2'd2;

  // memory port controls
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t raddr;
    byte_t wdata;
  } mem_ctl_t;

endpackage

/* hdl/i2c_sme_addr_unit.sv */
module i2c_sme_addr_unit
  import i2c_sme_pkg::*;
(
  input  au_op_t op,
  input  addr_t  clr_cnt,
  input  addr_t  pointer,
  input  addr_t  commit_addr,
  input  kidx_t  k,
  output addr_t  sum
);

  addr_t opa;
  addr_t opb;

  always_comb begin
    case (op)
      AU_CLR: begin
        opa = clr_cnt;
        opb = addr_t'(1);
      end
      AU_PTR: begin
        opa = pointer;
        opb = addr_t'(1);
      end
      AU_COMMIT: begin
        opa = commit_addr;
        opb = addr_t'(k);
      end
      default: begin
        opa = pointer;
        opb = '0;
      end
    endcase
  end

  // wraps at the memory size by width
  assign sum = opa + opb;

endmodule

/* hdl/i2c_sme_mem.sv */
module i2c_sme_mem
  import i2c_sme_pkg::*;
(
  input  logic     clk,
  input  mem_ctl_t ctl,
  input  addr_t    waddr,
  output byte_t    rdata
);

  byte_t mem_r [MEM_DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= ctl.wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem_r[ctl.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/i2c_slave_memory_emulation.sv */
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+------------------------------
// input    | in_saw_* .. in_data_lost, in_rx_byte   | accepted when start && !busy
// result   | out_tx_valid, out_tx_byte, out_committed, out_error_seen
//          |                                        | one-cycle strobe out_valid
//
// After reset a clearing pass writes 0xFF to all 32768 memory bytes, one a cycle;
// busy stays high for the whole pass.
// A transaction runs from accept through ST_EXEC to the strobe, via ST_RDWAIT when it
// reads memory, and via ST_COMMIT first when a stop or repeated start commits the buffer:
// the commit writes one byte per cycle through the single memory write port.
// The result strobe is held for one cycle; the receiver cannot stall it.
`include "i2c_slave_memory_emulation_macros.svh"

module i2c_slave_memory_emulation
  import i2c_sme_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  logic  in_saw_start,
  input  logic  in_saw_restart,
  input  logic  in_saw_stop,
  input  logic  in_saw_slave_select,
  input  logic  in_saw_error,
  input  logic  in_addr_matched,
  input  logic  in_byte_received,
  input  logic  in_read_request,
  input  logic  in_tx_empty,
  input  logic  in_data_lost,
  input  byte_t in_rx_byte,
  output logic  out_valid,
  output logic  out_tx_valid,
  output byte_t out_tx_byte,
  output logic  out_committed,
  output logic  out_error_seen
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_COMMIT = 3'd2;
  localparam logic [2:0] ST_EXEC   = 3'd3;
  localparam logic [2:0] ST_RDWAIT = 3'd4;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_RECV  = 2'd1;
  localparam logic [1:0] PH_XMIT  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  byte_t      addr_high_r, addr_high_nxt;
  logic       addr_pend_r, addr_pend_nxt;
  addr_t      pointer_r, pointer_nxt;
  addr_t      commit_addr_r, commit_addr_nxt;
  kidx_t      fill_r, fill_nxt;
  logic       data_pend_r, data_pend_nxt;
  byte_t      rx_buf_r [RECV_BYTES];
  logic       buf_we;
  addr_t      clr_cnt_r, clr_cnt_nxt;
  kidx_t      k_r, k_nxt;

  logic  matched_r, got_byte_r, rd_req_r, tx_emp_r;
  byte_t rxb_r;

  logic  out_valid_r, out_valid_nxt;
  logic  out_tx_valid_r, out_tx_valid_nxt;
  byte_t out_tx_byte_r, out_tx_byte_nxt;
  logic  out_committed_r, out_committed_nxt;
  logic  out_err_r, out_err_nxt;

  au_op_t   au_op;
  addr_t    au_sum;
  mem_ctl_t mem_ctl;
  byte_t    mem_rdata;
  logic     accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  i2c_sme_addr_unit u_addr (
    .op          (au_op),
    .clr_cnt     (clr_cnt_r),
    .pointer     (pointer_r),
    .commit_addr (commit_addr_r),
    .k           (k_r),
    .sum         (au_sum)
  );

  i2c_sme_mem u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (au_sum),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt         = state_r;
    phase_nxt         = phase_r;
    addr_high_nxt     = addr_high_r;
    addr_pend_nxt     = addr_pend_r;
    pointer_nxt       = pointer_r;
    commit_addr_nxt   = commit_addr_r;
    fill_nxt          = fill_r;
    data_pend_nxt     = data_pend_r;
    buf_we            = 1'b0;
    clr_cnt_nxt       = clr_cnt_r;
    k_nxt             = k_r;
    out_valid_nxt     = 1'b0;
    out_tx_valid_nxt  = 1'b0;
    out_tx_byte_nxt   = '0;
    out_committed_nxt = out_committed_r;
    out_err_nxt       = out_err_r;
    au_op             = AU_PTR;
    mem_ctl           = '0;

    case (state_r)
      ST_CLEAR: begin
        au_op         = AU_CLR;
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = 8'hFF;
        clr_cnt_nxt   = au_sum;
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          out_committed_nxt = 1'b0;
          out_err_nxt       = 1'b0;
          state_nxt         = ST_EXEC;
          k_nxt             = '0;
          if (in_saw_start) begin
            pointer_nxt = au_sum;
          end else if (in_saw_restart || in_saw_stop) begin
            if (phase_r == PH_RECV && data_pend_r) begin
              out_committed_nxt = 1'b1;
              state_nxt         = ST_COMMIT;
            end
            phase_nxt     = PH_START;
            data_pend_nxt = 1'b0;
          end else if (!in_saw_slave_select && in_saw_error) begin
            out_err_nxt = 1'b1;
          end
        end
      end
      ST_COMMIT: begin
        au_op         = AU_COMMIT;
        mem_ctl.we    = 1'b1;
        mem_ctl.wdata = rx_buf_r[k_r];
        k_nxt         = k_r + kidx_t'(1);
        if (k_r == kidx_t'(RECV_BYTES - 1)) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        case (phase_r)
          PH_START: begin
            if (matched_r) begin
              addr_pend_nxt = 1'b1;
              addr_high_nxt = rxb_r;
              phase_nxt     = PH_RECV;
            end else if (rd_req_r) begin
              mem_ctl.re    = 1'b1;
              mem_ctl.raddr = pointer_r;
              phase_nxt     = PH_XMIT;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_RDWAIT;
            end
          end
          PH_RECV: begin
            if (got_byte_r) begin
              if (addr_pend_r) begin
                pointer_nxt     = addr_t'({addr_high_r, rxb_r});
                commit_addr_nxt = addr_t'({addr_high_r, rxb_r});
                addr_pend_nxt   = 1'b0;
              end else begin
                buf_we        = 1'b1;
                fill_nxt      = (fill_r == kidx_t'(RECV_BYTES - 1)) ? '0
                                                                    : fill_r + kidx_t'(1);
                data_pend_nxt = 1'b1;
              end
            end
          end
          PH_XMIT: begin
            if (tx_emp_r) begin
              pointer_nxt   = au_sum;
              mem_ctl.re    = 1'b1;
              mem_ctl.raddr = au_sum;
              out_valid_nxt = 1'b0;
              state_nxt     = ST_RDWAIT;
            end
          end
          default: begin
          end
        endcase
      end
      ST_RDWAIT: begin
        state_nxt        = ST_IDLE;
        out_valid_nxt    = 1'b1;
        out_tx_valid_nxt = 1'b1;
        out_tx_byte_nxt  = mem_rdata;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_CLEAR;
      phase_r         <= PH_START;
      addr_high_r     <= '0;
      addr_pend_r     <= 1'b0;
      pointer_r       <= '0;
      commit_addr_r   <= '0;
      fill_r          <= '0;
      data_pend_r     <= 1'b0;
      clr_cnt_r       <= '0;
      k_r             <= '0;
      out_valid_r     <= 1'b0;
      out_tx_valid_r  <= 1'b0;
      out_committed_r <= 1'b0;
      out_err_r       <= 1'b0;
      for (int i = 0; i < RECV_BYTES; i++) begin
        rx_buf_r[i] <= '0;
      end
    end else begin
      state_r         <= state_nxt;
      phase_r         <= phase_nxt;
      addr_high_r     <= addr_high_nxt;
      addr_pend_r     <= addr_pend_nxt;
      pointer_r       <= pointer_nxt;
      commit_addr_r   <= commit_addr_nxt;
      fill_r          <= fill_nxt;
      data_pend_r     <= data_pend_nxt;
      clr_cnt_r       <= clr_cnt_nxt;
      k_r             <= k_nxt;
      out_valid_r     <= out_valid_nxt;
      out_tx_valid_r  <= out_tx_valid_nxt;
      out_committed_r <= out_committed_nxt;
      out_err_r       <= out_err_nxt;
      if (buf_we) begin
        rx_buf_r[fill_r] <= rxb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_tx_byte_r <= out_tx_byte_nxt;
    if (accept) begin
      matched_r  <= in_addr_matched;
      got_byte_r <= in_byte_received;
      rd_req_r   <= in_read_request;
      tx_emp_r   <= in_tx_empty;
      rxb_r      <= in_rx_byte;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_tx_valid   = out_tx_valid_r;
  assign out_tx_byte    = out_tx_byte_r;
  assign out_committed  = out_committed_r;
  assign out_error_seen = out_err_r;

  `I2C_SME_ASSERT_NXT(a_accept_busy, accept, busy)
  `I2C_SME_ASSERT_IMP(a_strobe_idle, out_valid, state_r == ST_IDLE)
  `I2C_SME_ASSERT_NXT(a_commit_end, (state_r == ST_COMMIT) && (k_r == kidx_t'(RECV_BYTES - 1)),
                      state_r == ST_EXEC)
  `I2C_SME_ASSERT_NXT(a_read_strobe, state_r == ST_RDWAIT, out_valid && out_tx_valid)
  `I2C_SME_ASSERT_IMP(a_commit_flag, state_r == ST_COMMIT, out_committed_r)

endmodule
